// ===== hdl/tlb_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the tour lower-bound engine.
// Used by tlb_ram and tour_lower_bound_engine_top; no dependencies.
package tlb_pkg;

  localparam int MAX_CITIES_DEF = 64;
  localparam int FRACTION_BITS  = 8;

  localparam int LEN_W        = 24;
  localparam int BOUND_W      = 32;
  localparam int ACC_W        = BOUND_W + 2;
  localparam int CITY_IN_W    = 6;
  localparam int OP_W         = 2;
  localparam int NUM_CITIES_W = 7;
  localparam int CEIL_W       = 23;
  localparam int CFG_INDEX_W  = 1;
  localparam int CFG_DATA_W   = 23;

  localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
  localparam logic [OP_W-1:0] OP_MINIMA = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] CFG_NUM_CITIES  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_CEILING = 1'd1;

  localparam logic [NUM_CITIES_W-1:0] NUM_CITIES_RESET  = 7'd64;
  localparam logic [CEIL_W-1:0]       MIN_CEILING_RESET = 23'd8388607;

  // no road: minus one in fixed point
  localparam logic signed [LEN_W-1:0] ABSENT_LENGTH = LEN_W'(-(1 << FRACTION_BITS));

  typedef struct packed {
    logic [OP_W-1:0]             operation;
    logic [CITY_IN_W-1:0]        from_city;
    logic [CITY_IN_W-1:0]        to_city;
    logic signed [LEN_W-1:0]     road_length;
    logic signed [BOUND_W-1:0]   parent_bound;
  } item_t;

  typedef struct packed {
    logic signed [BOUND_W-1:0] bound;
    logic                      status;
  } result_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WR_A,
    ST_WR_B,
    ST_MIN_NEXT,
    ST_MIN_SCAN,
    ST_MIN_ROW,
    ST_MIN_ACC,
    ST_Q_CHECK,
    ST_Q_D,
    ST_Q_T,
    ST_Q_SUM,
    ST_DONE
  } state_t;

endpackage

// ===== hdl/tlb_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Defaults from tlb_pkg.
module tlb_ram #(
  parameter int WIDTH = tlb_pkg::LEN_W,
  parameter int DEPTH = tlb_pkg::MAX_CITIES_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/tour_lower_bound_engine_top.sv =====
`timescale 1ns / 1ps
// Tour lower-bound engine: distance table, per-city minima and bound sequencer.
// Depends on tlb_pkg and tlb_ram.
//
// One item at a time; item_ready is high only while the sequencer is idle. After reset
// the distance table is swept to "no road" over all MAX_CITIES*MAX_CITIES entries (4096 at the
// default), during which no item is taken; configuration writes are taken at any time.
// A road write does two table writes before its result, one per direction. An edge
// query does one table read, two reads of the minima RAM and two passes through the
// shared 34-bit adder; a query ends with no-road status after the city check for a city
// out of use and after the table read for a missing road. The minima pass reads the
// table one entry per cycle through its single read port, row by row for the n cities in
// use. A result sits in an output register until taken; a finished item waits in the
// done state if the previous result has not yet been transferred.
module tour_lower_bound_engine_top #(
  parameter int MAX_CITIES = tlb_pkg::MAX_CITIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  output logic                             item_ready,
  input  tlb_pkg::item_t                   item,
  output logic                             result_valid,
  input  logic                             result_ready,
  output tlb_pkg::result_t                 result,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tlb_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [tlb_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import tlb_pkg::*;

  localparam int CITY_W = $clog2(MAX_CITIES);
  localparam int CNT_W  = $clog2(MAX_CITIES + 1);
  localparam int DEPTH  = MAX_CITIES * MAX_CITIES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int PAIR_W = 2 * LEN_W;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ADDR_W-1:0] row,
                                                  input logic [ADDR_W-1:0] col);
    return row * ADDR_W'(MAX_CITIES) + col;
  endfunction

  function automatic logic signed [BOUND_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [BOUND_W-1:0] r;
    if (v[ACC_W-1:BOUND_W-1] == '0 || v[ACC_W-1:BOUND_W-1] == '1) begin
      r = v[BOUND_W-1:0];
    end else if (v[ACC_W-1]) begin
      r = {1'b1, {(BOUND_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(BOUND_W-1){1'b1}}};
    end
    return r;
  endfunction

  state_t state, state_next;

  logic [ADDR_W-1:0]        clr_addr, clr_addr_next;
  item_t                    itm;
  logic [CNT_W-1:0]         i_cnt, i_next, j_cnt, j_next;
  logic                     rd_pend, rd_pend_next;
  logic signed [LEN_W-1:0]  m1, m1_next, m2, m2_next;
  logic signed [LEN_W-1:0]  d_q, d_next, half, half_next;
  logic [PAIR_W-1:0]        mf, mf_next;
  logic signed [ACC_W-1:0]  acc, acc_next;
  logic                     res_status, res_status_next;
  logic                     out_load;
  logic                     accept;

  logic [NUM_CITIES_W-1:0]  num_cities;
  logic [CEIL_W-1:0]        min_ceiling;
  logic [CNT_W-1:0]         ncity;
  logic signed [LEN_W-1:0]  ceil_s;
  logic                     wr_ok, q_ok;

  logic                     tbl_we;
  logic [ADDR_W-1:0]        tbl_waddr, tbl_raddr;
  logic [LEN_W-1:0]         tbl_wdata, tbl_rdata;
  logic signed [LEN_W-1:0]  td;
  logic                     min_we;
  logic [CITY_W-1:0]        min_waddr, min_raddr;
  logic [PAIR_W-1:0]        min_wdata, min_rdata;

  logic signed [ACC_W-1:0]  alu_a, alu_b, alu_sum;
  logic signed [LEN_W-1:0]  pair_a, pair_b;
  logic signed [LEN_W:0]    pair_sum;
  logic signed [LEN_W-1:0]  first_f, sec_f, first_t, sec_t, cf, ct;

  tlb_ram #(.WIDTH(LEN_W), .DEPTH(DEPTH)) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  tlb_ram #(.WIDTH(PAIR_W), .DEPTH(MAX_CITIES)) u_minima (
    .clk   (clk),
    .we    (min_we),
    .waddr (min_waddr),
    .wdata (min_wdata),
    .raddr (min_raddr),
    .rdata (min_rdata)
  );

  assign cfg_ready = 1'b1;
  assign accept    = item_valid && item_ready;
  assign ceil_s    = $signed({1'b0, min_ceiling});
  assign td        = $signed(tbl_rdata);

  always_comb begin
    if (32'(num_cities) > 32'(MAX_CITIES)) begin
      ncity = CNT_W'(MAX_CITIES);
    end else begin
      ncity = CNT_W'(num_cities);
    end
  end

  assign wr_ok = (32'(itm.from_city) < 32'(MAX_CITIES)) && (32'(itm.to_city) < 32'(MAX_CITIES));
  assign q_ok  = (32'(itm.from_city) < 32'(ncity)) && (32'(itm.to_city) < 32'(ncity));

  // minimum choice for the queried edge
  assign first_f = $signed(mf[PAIR_W-1:LEN_W]);
  assign sec_f   = $signed(mf[LEN_W-1:0]);
  assign first_t = $signed(min_rdata[PAIR_W-1:LEN_W]);
  assign sec_t   = $signed(min_rdata[LEN_W-1:0]);
  assign cf      = (d_q >= sec_f) ? sec_f : first_f;
  assign ct      = (d_q >= sec_t) ? sec_t : first_t;

  // shared adders
  assign pair_sum = $signed({pair_a[LEN_W-1], pair_a}) + $signed({pair_b[LEN_W-1], pair_b});
  assign alu_sum  = alu_a + alu_b;

  always_comb begin
    state_next      = state;
    clr_addr_next   = clr_addr;
    i_next          = i_cnt;
    j_next          = j_cnt;
    rd_pend_next    = rd_pend;
    m1_next         = m1;
    m2_next         = m2;
    d_next          = d_q;
    mf_next         = mf;
    half_next       = half;
    acc_next        = acc;
    res_status_next = res_status;
    out_load        = 1'b0;
    item_ready      = 1'b0;
    tbl_we          = 1'b0;
    tbl_waddr       = clr_addr;
    tbl_wdata       = ABSENT_LENGTH;
    tbl_raddr       = cell_addr(ADDR_W'(i_cnt), ADDR_W'(j_cnt));
    min_we          = 1'b0;
    min_waddr       = i_cnt[CITY_W-1:0];
    min_wdata       = {m1, m2};
    min_raddr       = CITY_W'(itm.from_city);
    alu_a           = acc;
    alu_b           = ACC_W'(half);
    pair_a          = m1;
    pair_b          = m2;

    unique case (state)
      ST_CLEAR: begin
        tbl_we        = 1'b1;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == ADDR_W'(DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          acc_next        = '0;
          res_status_next = 1'b0;
          i_next          = '0;
          unique case (item.operation)
            OP_WRITE:  state_next = ST_WR_A;
            OP_MINIMA: state_next = ST_MIN_NEXT;
            OP_QUERY:  state_next = ST_Q_CHECK;
            default:   state_next = ST_DONE;
          endcase
        end
      end
      ST_WR_A: begin
        tbl_we     = wr_ok;
        tbl_waddr  = cell_addr(ADDR_W'(itm.from_city), ADDR_W'(itm.to_city));
        tbl_wdata  = itm.road_length;
        state_next = ST_WR_B;
      end
      ST_WR_B: begin
        tbl_we     = wr_ok;
        tbl_waddr  = cell_addr(ADDR_W'(itm.to_city), ADDR_W'(itm.from_city));
        tbl_wdata  = itm.road_length;
        state_next = ST_DONE;
      end
      ST_MIN_NEXT: begin
        if (i_cnt < ncity) begin
          j_next       = '0;
          rd_pend_next = 1'b0;
          m1_next      = ceil_s;
          m2_next      = ceil_s;
          state_next   = ST_MIN_SCAN;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_MIN_SCAN: begin
        if (rd_pend && td > 0) begin
          if (td <= m1) begin
            m2_next = m1;
            m1_next = td;
          end else if (td <= m2) begin
            m2_next = td;
          end
        end
        if (j_cnt < ncity) begin
          j_next       = j_cnt + 1'b1;
          rd_pend_next = 1'b1;
        end else begin
          rd_pend_next = 1'b0;
          state_next   = ST_MIN_ROW;
        end
      end
      ST_MIN_ROW: begin
        min_we     = 1'b1;
        half_next  = LEN_W'(pair_sum >>> 1);
        state_next = ST_MIN_ACC;
      end
      ST_MIN_ACC: begin
        acc_next   = alu_sum;
        i_next     = i_cnt + 1'b1;
        state_next = ST_MIN_NEXT;
      end
      ST_Q_CHECK: begin
        tbl_raddr = cell_addr(ADDR_W'(itm.from_city), ADDR_W'(itm.to_city));
        if (q_ok) begin
          state_next = ST_Q_D;
        end else begin
          res_status_next = 1'b1;
          state_next      = ST_DONE;
        end
      end
      ST_Q_D: begin
        d_next    = td;
        mf_next   = min_rdata;
        min_raddr = CITY_W'(itm.to_city);
        if (td <= 0) begin
          res_status_next = 1'b1;
          state_next      = ST_DONE;
        end else begin
          state_next = ST_Q_T;
        end
      end
      ST_Q_T: begin
        pair_a     = cf;
        pair_b     = ct;
        half_next  = LEN_W'(pair_sum >>> 1);
        alu_a      = ACC_W'(itm.parent_bound);
        alu_b      = ACC_W'(d_q);
        acc_next   = alu_sum;
        state_next = ST_Q_SUM;
      end
      ST_Q_SUM: begin
        alu_b      = -(ACC_W'(half));
        acc_next   = alu_sum;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!result_valid || result_ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr     <= '0;
      result_valid <= 1'b0;
      num_cities   <= NUM_CITIES_RESET;
      min_ceiling  <= MIN_CEILING_RESET;
    end else begin
      clr_addr <= clr_addr_next;
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_NUM_CITIES:  num_cities  <= cfg_data[NUM_CITIES_W-1:0];
          CFG_MIN_CEILING: min_ceiling <= cfg_data[CEIL_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      itm <= item;
    end
    if (out_load) begin
      result.bound  <= sat32(acc);
      result.status <= res_status;
    end
    i_cnt      <= i_next;
    j_cnt      <= j_next;
    rd_pend    <= rd_pend_next;
    m1         <= m1_next;
    m2         <= m2_next;
    d_q        <= d_next;
    mf         <= mf_next;
    half       <= half_next;
    acc        <= acc_next;
    res_status <= res_status_next;
  end

endmodule

// ===== test/tb_tour_lower_bound_engine_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for tour_lower_bound_engine_top: road writes, minima passes and
// edge-bound queries, checked in order against a bound predictor held in a small class.
// Depends on tlb_pkg and the engine RTL only.
module tb_tour_lower_bound_engine_top;
  import tlb_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int    TABLE_DEPTH = MAX_CITIES_DEF * MAX_CITIES_DEF;
  localparam longint BOUND_HI   = (longint'(1) <<< (BOUND_W - 1)) - 1;
  localparam longint BOUND_LO   = -(longint'(1) <<< (BOUND_W - 1));
  localparam longint LEN_HI     = (longint'(1) <<< (LEN_W - 1)) - 1;
  localparam longint LEN_LO     = -(longint'(1) <<< (LEN_W - 1));
  localparam int    QUIET_LIMIT = 20000;
  localparam int    HOLD_CYCLES = 300;
  localparam int    PRINT_CAP   = 200;

  class lower_bound_tracker;
    logic signed [LEN_W-1:0] road_len [TABLE_DEPTH];
    logic signed [LEN_W-1:0] min_lo [MAX_CITIES_DEF];
    logic signed [LEN_W-1:0] min_hi [MAX_CITIES_DEF];
    bit                      minima_known [MAX_CITIES_DEF];
    logic [NUM_CITIES_W-1:0] cities;
    logic [CEIL_W-1:0]       ceiling;
    result_t                 expected_q [$];
    int unsigned writes, passes, queries, no_road, others, checked;

    function new();
      foreach (road_len[k]) road_len[k] = ABSENT_LENGTH;
      foreach (min_lo[k]) begin
        min_lo[k] = '0;
        min_hi[k] = '0;
        minima_known[k] = 1'b0;
      end
      cities  = NUM_CITIES_RESET;
      ceiling = MIN_CEILING_RESET;
    endfunction

    function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_NUM_CITIES:  cities = data[NUM_CITIES_W-1:0];
        CFG_MIN_CEILING: ceiling = data[CEIL_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned active_cities();
      return (cities > MAX_CITIES_DEF) ? MAX_CITIES_DEF : int'(cities);
    endfunction

    function logic signed [LEN_W-1:0] road(int unsigned f, int unsigned t);
      return road_len[f * MAX_CITIES_DEF + t];
    endfunction

    // a query that passes the road check reads both cities' minima
    function bit needs_minima(int unsigned f, int unsigned t);
      int unsigned n;
      n = active_cities();
      return f < n && t < n && road(f, t) > 0 && !(minima_known[f] && minima_known[t]);
    endfunction

    function int unsigned outstanding();
      return expected_q.size();
    endfunction

    function logic signed [BOUND_W-1:0] clamp_bound(longint v);
      if (v > BOUND_HI) return BOUND_W'(BOUND_HI);
      if (v < BOUND_LO) return BOUND_W'(BOUND_LO);
      return BOUND_W'(v);
    endfunction

    function longint pick_minimum(int unsigned c, logic signed [LEN_W-1:0] d);
      return (d >= min_hi[c]) ? longint'(min_hi[c]) : longint'(min_lo[c]);
    endfunction

    function void note_item(item_t it);
      result_t r;
      int unsigned n, f, t, i, j;
      logic signed [LEN_W-1:0] d, lo, hi;
      longint acc;
      r.bound  = '0;
      r.status = 1'b0;
      n = active_cities();
      f = it.from_city;
      t = it.to_city;
      case (it.operation)
        OP_WRITE: begin
          road_len[f * MAX_CITIES_DEF + t] = it.road_length;
          road_len[t * MAX_CITIES_DEF + f] = it.road_length;
          writes++;
        end
        OP_MINIMA: begin
          acc = 0;
          for (i = 0; i < n; i++) begin
            lo = LEN_W'(ceiling);
            hi = LEN_W'(ceiling);
            for (j = 0; j < n; j++) begin
              d = road(i, j);
              if (d > 0) begin
                if (d <= lo) begin
                  hi = lo;
                  lo = d;
                end else if (d <= hi) begin
                  hi = d;
                end
              end
            end
            min_lo[i] = lo;
            min_hi[i] = hi;
            minima_known[i] = 1'b1;
            acc += (longint'(lo) + longint'(hi)) >>> 1;
          end
          r.bound = clamp_bound(acc);
          passes++;
        end
        OP_QUERY: begin
          queries++;
          d = '0;
          if (f < n && t < n) d = road(f, t);
          if (d <= 0) begin
            r.status = 1'b1;
            no_road++;
          end else begin
            acc = longint'(it.parent_bound) + longint'(d)
                - ((pick_minimum(f, d) + pick_minimum(t, d)) >>> 1);
            r.bound = clamp_bound(acc);
          end
        end
        default: others++;
      endcase
      expected_q = {expected_q, r};
    endfunction

    function string check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0)
        return $sformatf("result with nothing pending: bound %0d status %0b",
                         got.bound, got.status);
      want = expected_q.pop_front();
      checked++;
      if (got.bound !== want.bound || got.status !== want.status)
        return $sformatf("result %0d: bound %0d status %0b, want bound %0d status %0b",
                         checked, got.bound, got.status, want.bound, want.status);
      return "";
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   item_valid = 1'b0;
  logic                   item_ready;
  item_t                  item = '0;
  logic                   result_valid;
  logic                   result_ready = 1'b0;
  result_t                result;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  lower_bound_tracker tracker = new;

  int unsigned sender_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_granted = 0;
  int unsigned hold_left = 0;
  int unsigned quiet = 0;
  int unsigned settings_used = 0;
  int          errors = 0;

  tour_lower_bound_engine_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= PRINT_CAP) $display("MISMATCH at %0t: %s", $time, what);
  endtask

  // result side: check, long hold-off on request, random stalls otherwise
  always @(posedge clk) begin
    string verdict;
    if (!rst && result_valid && result_ready) begin
      verdict = tracker.check_result(result);
      if (verdict != "") report_mismatch(verdict);
    end
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      result_ready <= 1'b0;
    end else if (holds_granted != hold_requests) begin
      holds_granted <= holds_granted + 1;
      hold_left <= HOLD_CYCLES;
      result_ready <= 1'b0;
    end else begin
      result_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((item_valid && item_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
      $display("tour_lower_bound_engine_top verification failed");
      $finish;
    end
  end

  task automatic configure(input int unsigned n, input int unsigned ceil_value);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_NUM_CITIES;
    cfg_data  <= CFG_DATA_W'(n);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.set_register(CFG_NUM_CITIES, CFG_DATA_W'(n));
    cfg_index <= CFG_MIN_CEILING;
    cfg_data  <= CFG_DATA_W'(ceil_value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.set_register(CFG_MIN_CEILING, CFG_DATA_W'(ceil_value));
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic send_item(input item_t it);
    if (sender_idle_pct != 0) begin
      while ($urandom_range(99) < sender_idle_pct) begin
        item_valid <= 1'b0;
        @(posedge clk);
      end
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    tracker.note_item(it);
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  function automatic item_t make_item(input logic [OP_W-1:0] op, input int unsigned f,
                                      input int unsigned t, input longint len,
                                      input longint parent);
    item_t it;
    it.operation    = op;
    it.from_city    = CITY_IN_W'(f);
    it.to_city      = CITY_IN_W'(t);
    it.road_length  = LEN_W'(len);
    it.parent_bound = BOUND_W'(parent);
    return it;
  endfunction

  // mostly writes and queries on roads in use; some out-of-range cities and noise
  function automatic item_t random_item(input int unsigned minima_pct);
    item_t       it;
    int unsigned n, f, t, j, roads, roll;
    int          k;
    it.road_length  = LEN_W'($urandom);
    it.parent_bound = BOUND_W'($urandom);
    n = tracker.active_cities();
    f = $urandom_range(n - 1);
    t = $urandom_range(n - 1);
    roll = $urandom_range(99);
    if (roll < minima_pct) begin
      it.operation = OP_MINIMA;
    end else if (roll < 45) begin
      it.operation = OP_WRITE;
      if ($urandom_range(9) == 0) begin
        f = $urandom_range(MAX_CITIES_DEF - 1);
        t = $urandom_range(MAX_CITIES_DEF - 1);
      end
      case ($urandom_range(9))
        0: it.road_length = LEN_W'($urandom);
        1: it.road_length = $urandom_range(1) ? '0 : ABSENT_LENGTH;
        2: it.road_length = LEN_W'(LEN_HI - $urandom_range(255));
        default: it.road_length = LEN_W'($urandom_range(8192, 1));
      endcase
    end else if (roll < 96) begin
      it.operation = OP_QUERY;
      if ($urandom_range(9) == 0) begin
        f = $urandom_range(MAX_CITIES_DEF - 1);
        t = $urandom_range(MAX_CITIES_DEF - 1);
      end else if ($urandom_range(3) != 0) begin
        roads = 0;
        for (j = 0; j < n; j++)
          if (tracker.road(f, j) > 0) roads++;
        if (roads != 0) begin
          k = $urandom_range(roads - 1);
          for (j = 0; j < n; j++)
            if (tracker.road(f, j) > 0) begin
              if (k == 0) t = j;
              k--;
            end
        end
      end
      case ($urandom_range(7))
        0: it.parent_bound = BOUND_W'($urandom);
        1: it.parent_bound = BOUND_W'(BOUND_HI - $urandom_range(4096));
        2: it.parent_bound = BOUND_W'(BOUND_LO + $urandom_range(4096));
        default: it.parent_bound = BOUND_W'($urandom_range(32'h003F_FFFF));
      endcase
      if (tracker.needs_minima(f, t)) it.operation = OP_MINIMA;
    end else begin
      it.operation = OP_UNUSED;
    end
    it.from_city = CITY_IN_W'(f);
    it.to_city   = CITY_IN_W'(t);
    return it;
  endfunction

  task automatic run_phase(input int unsigned n, input int unsigned ceil_value,
                           input int unsigned count, input int unsigned send_pct,
                           input int unsigned stall, input int unsigned minima_pct,
                           input bit hold, input bit pause_mid);
    int unsigned i;
    configure(n, ceil_value);
    sender_idle_pct = send_pct;
    stall_pct = stall;
    if (hold) hold_requests++;
    for (i = 0; i < count; i++) begin
      send_item(random_item(minima_pct));
      if (pause_mid && i == count / 2) drain();
    end
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    // table clear sweep runs now; registers are taken meanwhile
    configure(8, MIN_CEILING_RESET);

    send_item(make_item(OP_MINIMA, 0, 0, 0, 0));
    send_item(make_item(OP_WRITE, 0, 1, 256, 0));
    send_item(make_item(OP_WRITE, 1, 2, LEN_HI, 0));
    send_item(make_item(OP_WRITE, 0, 2, 1, 0));
    send_item(make_item(OP_WRITE, 2, 3, 0, 0));
    send_item(make_item(OP_WRITE, 3, 4, LEN_LO, 0));
    send_item(make_item(OP_WRITE, 5, 5, 300, 0));
    send_item(make_item(OP_WRITE, 1, 3, 100, 0));
    send_item(make_item(OP_WRITE, 63, 62, 512, 0));
    send_item(make_item(OP_WRITE, 6, 7, ABSENT_LENGTH, 0));
    send_item(make_item(OP_UNUSED, 63, 63, -1, -1));
    send_item(make_item(OP_MINIMA, 0, 0, 0, 0));
    send_item(make_item(OP_QUERY, 0, 1, 0, 0));
    send_item(make_item(OP_QUERY, 1, 2, 0, BOUND_HI));
    // new short road after the pass: stale minima push the bound under the floor
    send_item(make_item(OP_WRITE, 4, 5, 1, 0));
    send_item(make_item(OP_QUERY, 4, 5, 0, BOUND_LO));
    send_item(make_item(OP_QUERY, 2, 3, 0, 1000));
    send_item(make_item(OP_QUERY, 3, 4, 0, 1000));
    send_item(make_item(OP_QUERY, 6, 7, 0, 1000));
    send_item(make_item(OP_QUERY, 62, 63, 0, 1000));
    send_item(make_item(OP_QUERY, 5, 5, 0, 12345));
    send_item(make_item(OP_QUERY, 0, 7, 0, -5000));
    drain();

    run_phase(2, 0, 60, 0, 0, 10, 1'b0, 1'b0);
    run_phase(12, MIN_CEILING_RESET, 100, 74, 0, 8, 1'b0, 1'b1);
    run_phase(6, 1536, 90, 0, 74, 10, 1'b1, 1'b0);
    run_phase(64, MIN_CEILING_RESET, 40, 18, 18, 3, 1'b0, 1'b0);
    run_phase(100, 1000, 30, 0, 0, 5, 1'b0, 1'b0);
    run_phase(10, 12345, 100, 18, 18, 8, 1'b0, 1'b0);
    run_phase(4, 777, 90, 0, 0, 10, 1'b1, 1'b1);

    repeat (20) @(posedge clk);
    $display("Run covered %0d road writes, %0d minima passes, %0d edge queries (%0d with no road)",
             tracker.writes, tracker.passes, tracker.queries, tracker.no_road);
    $display("plus %0d unused-opcode items; %0d results checked over %0d register settings.",
             tracker.others, tracker.checked, settings_used);
    if (errors == 0) begin
      $display("tour_lower_bound_engine_top verification clean");
    end else begin
      $display("tour_lower_bound_engine_top verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/tlb_pkg.sv
hdl/tlb_ram.sv
hdl/tour_lower_bound_engine_top.sv
test/tb_tour_lower_bound_engine_top.sv
